@@ rtl/element_slot_free_list_macros.svh @@
// Assertion macros shared by the slot free-list RTL.
// Depends on nothing; files that check their logic include it.
`ifndef ELEMENT_SLOT_FREE_LIST_MACROS_SVH
`define ELEMENT_SLOT_FREE_LIST_MACROS_SVH

// Same-cycle implication, quiet while reset is high.
`define ESFL_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, quiet while reset is high.
`define ESFL_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/esfl_pkg.sv @@
// Types and constants of the slot free-list allocator.
// Depends on nothing; used by element_slot_free_list.
package esfl_pkg;

   localparam int CAPACITY = 1024;
   localparam int SLOT_W = 10;
   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(CAPACITY - 1);

   typedef enum logic [1:0] {
      FUNC_ALLOC   = 2'd0,
      FUNC_RELEASE = 2'd1,
      FUNC_INIT    = 2'd2
   } func_type;

   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_FULL    = 2'd1;
   localparam logic [1:0] STATUS_INVALID = 2'd2;

   typedef struct packed {
      logic [1:0]        func;
      logic [SLOT_W-1:0] slot_index;
   } req_type;

   typedef struct packed {
      logic [SLOT_W-1:0] slot;
      logic [1:0]        status;
      logic [SLOT_W-1:0] high_water;
   } rsp_type;

   // One word of the slot memory: valid bit and free-list link.
   typedef struct packed {
      logic              valid;
      logic [SLOT_W-1:0] link;
   } entry_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_ALLOC,
      ST_REL,
      ST_WALK,
      ST_INIT,
      ST_RESULT
   } state_type;

endpackage

@@ rtl/element_slot_free_list.sv @@
// Slot allocator with a linked free list and a high-water mark.
// Depends on esfl_pkg and element_slot_free_list_macros.svh.
//
// Allocate and release read the single slot memory that holds each slot's valid
// bit and free-list link; the read data is registered, and the result waits
// for it. Unused function codes read nothing and answer with STATUS_OK.
// Releasing the high-water slot also walks the mark down, slot by slot, to the
// next valid slot or to slot 0. Initialize sweeps the whole memory, one entry a
// cycle. After reset the block runs the same sweep over all CAPACITY entries to
// clear all valid bits and accepts no request until it is done; csr writes are
// taken at all times. A request is accepted while an earlier result still waits
// on rsp_stall; its own result is then loaded only once that earlier result is
// taken.
module element_slot_free_list (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  esfl_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output esfl_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [esfl_pkg::SLOT_W-1:0] csr_data
);
   import esfl_pkg::*;
   `include "element_slot_free_list_macros.svh"

   state_type         state_ff, state_in;
   req_type           req_ff, req_in;
   logic [SLOT_W-1:0] head_ff, head_in;
   logic [SLOT_W-1:0] top_ff, top_in;
   logic [SLOT_W-1:0] cnt_ff, cnt_in;
   logic [SLOT_W-1:0] walk_ff, walk_in;
   logic [SLOT_W-1:0] initial_used_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_data_ff, rsp_data_in;

   entry_type         entry_mem_ff [CAPACITY];
   entry_type         rd_data_ff;
   logic [SLOT_W-1:0] rd_addr;
   logic              wr_en;
   logic [SLOT_W-1:0] wr_addr;
   entry_type         wr_data;

   logic              finish_ok;
   logic              walk_stop;
   logic              emit;
   rsp_type           emit_data;
   logic [SLOT_W-1:0] sweep_used;
   entry_type         sweep_entry;

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign csr_ready = 1'b1;

   // A result can be loaded when the output register is empty or being taken.
   assign finish_ok = !rsp_valid_ff || !rsp_stall;
   assign walk_stop = (walk_ff == '0) || rd_data_ff.valid;

   // The reset sweep is an initialize with no occupied slots.
   assign sweep_used = (state_ff == ST_INIT) ? initial_used_ff : '0;
   always_comb begin
      sweep_entry.valid = (cnt_ff != '0) && (cnt_ff <= sweep_used);
      sweep_entry.link  = ((cnt_ff > sweep_used) && (cnt_ff != LAST_SLOT)) ?
                          cnt_ff + SLOT_W'(1) : '0;
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (cnt_ff == LAST_SLOT) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) begin
               priority case (req_data.func)
                  FUNC_ALLOC:   state_in = (head_ff != '0) ? ST_ALLOC : ST_RESULT;
                  FUNC_RELEASE: state_in = (req_data.slot_index != '0) ? ST_REL : ST_RESULT;
                  FUNC_INIT:    state_in = ST_INIT;
                  default:      state_in = ST_RESULT;
               endcase
            end
         end
         ST_ALLOC: begin
            if (finish_ok) state_in = ST_IDLE;
         end
         ST_REL: begin
            if (rd_data_ff.valid && (req_ff.slot_index == top_ff)) begin
               state_in = ST_WALK;
            end else if (finish_ok) begin
               state_in = ST_IDLE;
            end
         end
         ST_WALK: begin
            if (walk_stop && finish_ok) state_in = ST_IDLE;
         end
         ST_INIT: begin
            if ((cnt_ff == LAST_SLOT) && finish_ok) state_in = ST_IDLE;
         end
         ST_RESULT: begin
            if (finish_ok) state_in = ST_IDLE;
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   // Datapath, memory port and result.
   always_comb begin
      rd_addr   = head_ff;
      wr_en     = 1'b0;
      wr_addr   = cnt_ff;
      wr_data   = '0;
      head_in   = head_ff;
      top_in    = top_ff;
      cnt_in    = cnt_ff;
      walk_in   = walk_ff;
      req_in    = req_ff;
      emit      = 1'b0;
      emit_data = '{slot: '0, status: STATUS_OK, high_water: top_ff};
      unique case (state_ff)
         ST_CLEAR, ST_INIT: begin
            wr_en   = 1'b1;
            wr_addr = cnt_ff;
            wr_data = sweep_entry;
            if (cnt_ff != LAST_SLOT) begin
               cnt_in = cnt_ff + SLOT_W'(1);
            end else if (state_ff == ST_CLEAR) begin
               cnt_in = '0;
            end else if (finish_ok) begin
               cnt_in    = '0;
               top_in    = initial_used_ff;
               head_in   = (initial_used_ff != LAST_SLOT) ?
                           initial_used_ff + SLOT_W'(1) : '0;
               emit      = 1'b1;
               emit_data.high_water = initial_used_ff;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               req_in  = req_data;
               rd_addr = (req_data.func == FUNC_RELEASE) ? req_data.slot_index : head_ff;
            end
         end
         ST_ALLOC: begin
            rd_addr = head_ff;
            if (finish_ok) begin
               wr_en      = 1'b1;
               wr_addr    = head_ff;
               wr_data    = '{valid: 1'b1, link: '0};
               head_in    = rd_data_ff.link;
               top_in     = (head_ff > top_ff) ? head_ff : top_ff;
               emit       = 1'b1;
               emit_data.slot       = head_ff;
               emit_data.high_water = top_in;
            end
         end
         ST_REL: begin
            rd_addr = req_ff.slot_index;
            if (!rd_data_ff.valid) begin
               if (finish_ok) begin
                  emit             = 1'b1;
                  emit_data.status = STATUS_INVALID;
               end
            end else if (req_ff.slot_index == top_ff) begin
               // The mark walks down; the result waits for the walk.
               wr_en   = 1'b1;
               wr_addr = req_ff.slot_index;
               wr_data = '{valid: 1'b0, link: head_ff};
               head_in = req_ff.slot_index;
               walk_in = req_ff.slot_index - SLOT_W'(1);
               rd_addr = walk_in;
            end else if (finish_ok) begin
               wr_en   = 1'b1;
               wr_addr = req_ff.slot_index;
               wr_data = '{valid: 1'b0, link: head_ff};
               head_in = req_ff.slot_index;
               emit    = 1'b1;
            end
         end
         ST_WALK: begin
            // One read is in flight each cycle; the data now is for walk_ff.
            if (!walk_stop) begin
               walk_in = walk_ff - SLOT_W'(1);
               rd_addr = walk_in;
            end else begin
               rd_addr = walk_ff;
               if (finish_ok) begin
                  top_in               = walk_ff;
                  emit                 = 1'b1;
                  emit_data.high_water = walk_ff;
               end
            end
         end
         ST_RESULT: begin
            if (finish_ok) begin
               emit = 1'b1;
               priority case (req_ff.func)
                  FUNC_ALLOC:   emit_data.status = STATUS_FULL;
                  FUNC_RELEASE: emit_data.status = STATUS_INVALID;
                  default:      emit_data.status = STATUS_OK;
               endcase
            end
         end
         default: begin
            cnt_in = '0;
         end
      endcase
   end

   assign rsp_valid_in = emit || (rsp_valid_ff && rsp_stall);
   assign rsp_data_in  = emit ? emit_data : rsp_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= entry_mem_ff[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_CLEAR;
         head_ff         <= SLOT_W'(1);
         top_ff          <= '0;
         cnt_ff          <= '0;
         rsp_valid_ff    <= 1'b0;
         initial_used_ff <= '0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         top_ff       <= top_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            initial_used_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      walk_ff     <= walk_in;
      rsp_data_ff <= rsp_data_in;
   end

   `ESFL_ASSERT_NOW(a_walk_below_top, clock, reset, state_ff == ST_WALK,
      walk_ff < top_ff, "high-water walk started at or above the mark")
   `ESFL_ASSERT_NEXT(a_alloc_under_mark, clock, reset,
      (state_ff == ST_ALLOC) && finish_ok, top_ff >= rsp_data_ff.slot,
      "allocated slot lies above the high-water mark")
   `ESFL_ASSERT_NOW(a_write_states, clock, reset, wr_en,
      (state_ff == ST_ALLOC) || (state_ff == ST_REL) || (state_ff == ST_INIT) ||
      (state_ff == ST_CLEAR), "slot memory written outside a writing state")
   `ESFL_ASSERT_NOW(a_alloc_head_nonzero, clock, reset, state_ff == ST_ALLOC,
      head_ff != '0, "allocate began with an empty free list")

endmodule
